// File: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_NEXT,
		S_MUL,
		S_SQR,
		S_DONE
	} state_t;

	// Operations of the shared modular unit.
	typedef enum logic {
		OP_MUL,
		OP_REDUCE
	} mexp_op_t;

	// Request from the sequencer to the modular unit.
	typedef struct packed {
		logic     start;
		mexp_op_t op;
	} mexp_req_t;

endpackage

// File: rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels of the modular exponentiation block: operand input,
// result output and configuration writes.
// ----------------------------------------------------------------------------
interface mexp_in_if #(
	parameter int W = 31
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink (input valid, input base_value, output ready);
endinterface

interface mexp_out_if #(
	parameter int W = 31
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if
	import mexp_pkg::*;
#(
	parameter int W = 32
) ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [W-1:0]            wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each input value to the configured exponent modulo the configured
// modulus (textbook RSA encryption or decryption).
// ----------------------------------------------------------------------------
// One item is worked on at a time. The base is first reduced modulo the
// modulus, then the exponent is scanned from its low bit by square and
// multiply: each one bit costs a multiplication and every bit below the
// highest one costs a squaring, and each product is formed on the single
// shift-and-add modular unit. Exponents with few ones thus finish sooner.
// A zero exponent returns 1, and otherwise a modulus of 0 or 1 returns 0;
// both answers appear in the cycle after the item is taken. The result
// sits in an output register, and a new item is taken once that register
// is free or is being read. Configuration writes are always taken and
// must only be made while no item is in flight.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mexp_in_if.sink    base_in,
	mexp_out_if.source result_out,
	mexp_cfg_if.sink   cfg
);

	state_t              state_q;
	state_t              state_d;
	logic [MOD_BITS-1:0] modulus_q;
	logic [EXP_BITS-1:0] exponent_q;
	logic [EXP_BITS-1:0] exp_left_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] base_q;
	logic [MOD_BITS-1:0] res_q;
	logic                res_valid_q;

	logic                in_fire;
	logic                out_free;
	logic                trivial;
	mexp_req_t           req;
	logic [MOD_BITS-1:0] unit_x;
	logic [MOD_BITS-1:0] unit_y;
	logic                unit_done;
	logic [MOD_BITS-1:0] unit_res;

	assign out_free = !res_valid_q || result_out.ready;
	assign in_fire  = base_in.valid && base_in.ready;
	// Zero exponent and moduli of 0 or 1 are answered without the unit.
	assign trivial  = (exponent_q == '0) || (modulus_q <= MOD_BITS'(1));

	assign base_in.ready       = (state_q == S_IDLE) && out_free;
	assign result_out.valid    = res_valid_q;
	assign result_out.power_result = res_q;
	assign cfg.ready           = 1'b1;

	mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.x_in  (unit_x),
		.y_in  (unit_y),
		.m_in  (modulus_q),
		.done  (unit_done),
		.result(unit_res)
	);

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.op    = OP_MUL;
		unit_x    = acc_q;
		unit_y    = base_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && !trivial) begin
					req.start = 1'b1;
					req.op    = OP_REDUCE;
					unit_y    = base_in.base_value;
					state_d   = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (unit_done) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (exp_left_q == '0) begin
					state_d = S_DONE;
				end else if (exp_left_q[0]) begin
					req.start = 1'b1;
					state_d   = S_MUL;
				end else begin
					req.start = 1'b1;
					unit_x    = base_q;
					state_d   = S_SQR;
				end
			end
			S_MUL, S_SQR: begin
				if (unit_done) begin
					state_d = S_NEXT;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			modulus_q   <= MOD_BITS'(2);
			exponent_q  <= EXP_BITS'(1);
		end else begin
			state_q <= state_d;
			if ((in_fire && trivial) || (state_q == S_DONE && out_free)) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MODULUS:  modulus_q  <= cfg.wdata[MOD_BITS-1:0];
					CFG_EXPONENT: exponent_q <= cfg.wdata[EXP_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			exp_left_q <= exponent_q;
			res_q      <= (exponent_q == '0) ? MOD_BITS'(1) : '0;
		end else if (state_q == S_DONE && out_free) begin
			res_q <= acc_q;
		end
		case (state_q)
			S_REDUCE: begin
				if (unit_done) begin
					base_q <= unit_res;
					acc_q  <= MOD_BITS'(1);
				end
			end
			S_MUL: begin
				// Clearing the low bit sends the sequencer on to the squaring, or to the end when no bits are left.
				if (unit_done) begin
					acc_q         <= unit_res;
					exp_left_q[0] <= 1'b0;
				end
			end
			S_SQR: begin
				if (unit_done) begin
					base_q     <= unit_res;
					exp_left_q <= exp_left_q >> 1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR))
		else $error("modular unit finished outside a wait state");

	a_done_exp_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (exp_left_q == '0))
		else $error("result delivered with exponent bits left");

	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEXT) |-> (acc_q < modulus_q && base_q < modulus_q))
		else $error("running product or base not reduced");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past((state_q == S_DONE) || in_fire))
		else $error("result appeared without an item to finish");
`endif

endmodule

// File: rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Shared modular unit. OP_MUL forms x*y mod m by shift and add, one
// multiplier bit per cycle, stopping when the multiplier runs out of ones.
// OP_REDUCE forms y mod m by restoring remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mexp_req_t           req,
	input  logic [MOD_BITS-1:0] x_in,
	input  logic [MOD_BITS-1:0] y_in,
	input  logic [MOD_BITS-1:0] m_in,
	output logic                done,
	output logic [MOD_BITS-1:0] result
);

	localparam int CNT_W = $clog2(MOD_BITS + 1);

	logic                busy_q;
	mexp_op_t            op_q;
	logic [MOD_BITS-1:0] x_q;
	logic [MOD_BITS-1:0] y_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] m_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [MOD_BITS:0]   acc_sum;
	logic [MOD_BITS-1:0] acc_next;
	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS-1:0] x_next;
	logic                finish;

	// Both operands stay below m, so one conditional subtract is enough.
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, x_q};
		if (acc_sum >= {1'b0, m_q}) begin
			acc_next = MOD_BITS'(acc_sum - {1'b0, m_q});
		end else begin
			acc_next = acc_sum[MOD_BITS-1:0];
		end
		// The doubler is shared: remainder steps shift in the next dividend bit.
		if (op_q == OP_REDUCE) begin
			dbl = {x_q, y_q[MOD_BITS-1]};
		end else begin
			dbl = {x_q, 1'b0};
		end
		if (dbl >= {1'b0, m_q}) begin
			x_next = MOD_BITS'(dbl - {1'b0, m_q});
		end else begin
			x_next = dbl[MOD_BITS-1:0];
		end
		if (op_q == OP_REDUCE) begin
			finish = busy_q && (cnt_q == '0);
		end else begin
			finish = busy_q && (y_q == '0);
		end
	end

	assign done   = finish;
	assign result = (op_q == OP_REDUCE) ? x_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= OP_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= (req.op == OP_REDUCE) ? '0 : x_in;
			y_q   <= y_in;
			acc_q <= '0;
			m_q   <= m_in;
			cnt_q <= CNT_W'(MOD_BITS);
		end else if (busy_q && !finish) begin
			x_q <= x_next;
			if (op_q == OP_REDUCE) begin
				y_q   <= {y_q[MOD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_next;
				end
				y_q <= {1'b0, y_q[MOD_BITS-1:1]};
			end
		end
	end

endmodule

// File: tb/modular_exponentiation_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the modular exponentiation block. A directed table
// covers reset values, zero and degenerate moduli, zero exponents, extreme
// widths and a small RSA key pair. Random phases with new modulus and
// exponent settings follow. Results are checked against table values or a
// local square-and-multiply predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module modular_exponentiation_test
	import mexp_pkg::*;
();

	localparam int MOD_BITS      = 31;
	localparam int EXP_BITS      = 32;
	localparam int RANDOM_ITEMS  = 245;
	localparam int CALM_ITEMS    = 30;
	localparam int HOLD_CYCLES   = 3000;
	localparam int ITEM_LATENCY  = 2300;
	localparam int NUM_DIRECTED  = 22;
	localparam logic [MOD_BITS-1:0] MOD_MAX = '1;

	typedef struct packed {
		logic [31:0]         mod_wd;
		logic [EXP_BITS-1:0] exp_wd;
		logic [MOD_BITS-1:0] base;
		logic                known;
		logic [MOD_BITS-1:0] want;
	} dir_row_t;

	// Rows marked known carry a result that follows directly from the
	// operands; the rest are left to the predictor.
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{32'd2, 32'd1, 31'd0, 1'b1, 31'd0},
		'{32'd2, 32'd1, MOD_MAX, 1'b1, 31'd1},
		'{32'd2, 32'd1, 31'h2AAA_AAAA, 1'b1, 31'd0},
		'{32'h7FFF_FFFF, 32'd0, 31'd0, 1'b1, 31'd1},
		'{32'h7FFF_FFFF, 32'd0, MOD_MAX, 1'b1, 31'd1},
		'{32'd0, 32'd0, 31'd5, 1'b1, 31'd1},
		'{32'd1, 32'd0, 31'd7, 1'b1, 31'd1},
		'{32'd0, 32'd5, 31'd9, 1'b1, 31'd0},
		'{32'd0, 32'hFFFF_FFFF, MOD_MAX, 1'b1, 31'd0},
		'{32'd1, 32'hFFFF_FFFF, 31'h5555_5555, 1'b1, 31'd0},
		'{32'd1, 32'd1, 31'd0, 1'b1, 31'd0},
		'{32'h7FFF_FFFF, 32'd1, MOD_MAX, 1'b1, 31'd0},
		'{32'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFE},
		'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFE},
		'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd2, 1'b0, 31'd0},
		'{32'h8000_000D, 32'd2, MOD_MAX, 1'b0, 31'd0},
		'{32'h8000_000D, 32'd2, 31'd12, 1'b1, 31'd1},
		'{32'd3233, 32'd17, 31'd65, 1'b1, 31'd2790},
		'{32'd3233, 32'd2753, 31'd2790, 1'b1, 31'd65},
		'{32'd1000, 32'd3, 31'd1999999, 1'b0, 31'd0},
		'{32'd2, 32'hFFFF_FFFF, 31'd3, 1'b1, 31'd1},
		'{32'h4000_0001, 32'h8000_0000, 31'h3FFF_FFFF, 1'b0, 31'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mexp_in_if #(.W(MOD_BITS)) base_in ();
	mexp_out_if #(.W(MOD_BITS)) result_out ();
	mexp_cfg_if #(.W(EXP_BITS)) cfg ();

	modular_exponentiation #(
		.MOD_BITS(MOD_BITS),
		.EXP_BITS(EXP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.base_in(base_in),
		.result_out(result_out),
		.cfg(cfg)
	);

	// Register copies as the block should hold them.
	logic [MOD_BITS-1:0] mod_now = 31'd2;
	logic [EXP_BITS-1:0] exp_now = 32'd1;
	logic [31:0]         mod_wd_now = 32'd2;

	logic [MOD_BITS-1:0] pending_powers [$];
	logic [MOD_BITS-1:0] oldest_power;
	int                  fault_count = 0;
	bit                  sender_gaps = 1'b0;
	bit                  receiver_gaps = 1'b0;
	bit                  hold_results = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [MOD_BITS-1:0] rsa_power(input logic [MOD_BITS-1:0] base);
		longint unsigned     m;
		longint unsigned     acc;
		longint unsigned     sq;
		logic [EXP_BITS-1:0] e;
		if (exp_now == '0)
			return 31'd1;
		if (mod_now <= 31'd1)
			return 31'd0;
		m = 64'(mod_now);
		sq = base % m;
		acc = 1;
		e = exp_now;
		while (e != '0) begin
			if (e[0])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
			e = e >> 1;
		end
		return acc[MOD_BITS-1:0];
	endfunction

	// Offers one item and files its expected power once the block takes it.
	task automatic offer_base(input logic [MOD_BITS-1:0] base, input logic [MOD_BITS-1:0] power);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 2) == 0) begin
			base_in.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		base_in.valid <= 1'b1;
		base_in.base_value <= base;
		do @(posedge clk); while (!base_in.ready);
		pending_powers = {pending_powers, power};
	endtask

	task automatic drain_results();
		@(negedge clk);
		base_in.valid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] mod_wd, input logic [EXP_BITS-1:0] exp_wd);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_MODULUS;
		cfg.wdata <= mod_wd;
		do @(posedge clk); while (!cfg.ready);
		mod_now = mod_wd[MOD_BITS-1:0];
		mod_wd_now = mod_wd;
		@(negedge clk);
		cfg.index <= CFG_EXPONENT;
		cfg.wdata <= exp_wd;
		do @(posedge clk); while (!cfg.ready);
		exp_now = exp_wd;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		result_out.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				result_out.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			result_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (result_out.valid && result_out.ready) begin
			if (pending_powers.size() == 0) begin
				$error("power_result: expected none, actual %0d", result_out.power_result);
				fault_count++;
			end else begin
				oldest_power = pending_powers.pop_front();
				if (result_out.power_result !== oldest_power) begin
					$error("power_result: expected %0d, actual %0d",
						oldest_power, result_out.power_result);
					fault_count++;
				end
			end
		end
	end

	initial begin
		int                  row;
		int                  items_sent;
		int                  phase_items;
		logic [31:0]         mod_wd;
		logic [EXP_BITS-1:0] exp_wd;
		logic [MOD_BITS-1:0] base;

		base_in.valid <= 1'b0;
		base_in.base_value <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_MODULUS;
		cfg.wdata <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		for (row = 0; row < NUM_DIRECTED; row++) begin
			if (directed_rows[row].mod_wd != mod_wd_now
					|| directed_rows[row].exp_wd != exp_now) begin
				drain_results();
				write_config(directed_rows[row].mod_wd, directed_rows[row].exp_wd);
			end
			base = directed_rows[row].base;
			offer_base(base, directed_rows[row].known ? directed_rows[row].want
				: rsa_power(base));
		end

		// A short exponent keeps items quick, so the held-off result side
		// backs the block up into its input.
		drain_results();
		write_config($urandom | 32'h4000_0000, 32'd3);
		@(posedge clk);
		hold_results = 1'b1;
		for (row = 0; row < 10; row++) begin
			base = MOD_BITS'($urandom);
			offer_base(base, rsa_power(base));
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			drain_results();
			sender_gaps = items_sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) != 0;
			receiver_gaps = items_sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 11))
				0:       mod_wd = $urandom_range(0, 1);
				1:       mod_wd = 32'd2;
				2:       mod_wd = 32'h7FFF_FFFF;
				3, 4:    mod_wd = $urandom_range(3, 65535);
				default: mod_wd = $urandom | 32'h4000_0000;
			endcase
			case ($urandom_range(0, 11))
				0:       exp_wd = '0;
				1:       exp_wd = '1;
				2, 3:    exp_wd = $urandom_range(1, 70000);
				4:       exp_wd = 32'd1 << $urandom_range(0, 31);
				default: exp_wd = $urandom;
			endcase
			write_config(mod_wd, exp_wd);
			phase_items = $urandom_range(4, 16);
			for (row = 0; row < phase_items && items_sent < RANDOM_ITEMS; row++) begin
				case ($urandom_range(0, 9))
					0:       base = '0;
					1:       base = MOD_MAX;
					2:       base = mod_now - 31'd1;
					3:       base = MOD_BITS'($urandom_range(0, mod_now));
					default: base = MOD_BITS'($urandom);
				endcase
				if (sender_gaps && $urandom_range(0, 11) == 0)
					drain_results();
				offer_base(base, rsa_power(base));
				items_sent++;
			end
		end

		drain_results();
		repeat (ITEM_LATENCY) @(posedge clk);
		if (fault_count == 0 && pending_powers.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
